>>> rtl/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg: shared types and codes of the block cache tag engine
// Slot states, request kinds, result status codes and the slot store
// read/write bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bcl_pkg;

   localparam int SLOTS    = 8;
   localparam int AGE_BITS = 16;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BLOCK_W  = 16;
   localparam int BIF_W    = 17;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int SLOT_OUT_W = 3;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   // slot states
   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_USED  = 2'd1;
   localparam logic [1:0] ST_FIXED = 2'd2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIX       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNFIX     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNFIX_ALL = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FLUSH     = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_HIT        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS_FILL  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_THROUGH    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FIX_FAILED = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FLUSH_WB   = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 3'd6;

   typedef struct packed {
      logic [BLOCK_W-1:0]  block;
      logic [1:0]          state;
      logic [AGE_BITS-1:0] age;
   } bcl_rd_type;

   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   addr;
      logic                set_block;
      logic [BLOCK_W-1:0]  block;
      logic                set_state;
      logic [1:0]          state;
      logic                set_age;
      logic [AGE_BITS-1:0] age;
   } bcl_wr_type;

endpackage

`default_nettype wire

>>> rtl/bcl_store.sv
// ----------------------------------------------------------------------------
// bcl_store: slot tag store
// Block number, state and age per slot; one read port at the scan index,
// one write port, and the occupancy vector for flush lookahead.
// ----------------------------------------------------------------------------
`default_nettype none

module bcl_store (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  [bcl_pkg::SLOT_W-1:0] rd_addr,
   output bcl_pkg::bcl_rd_type        rd_data,
   input  wire  bcl_pkg::bcl_wr_type  wr,
   output logic [bcl_pkg::SLOTS-1:0]  occ_mask
);

   logic [bcl_pkg::BLOCK_W-1:0]  block_ff [bcl_pkg::SLOTS];
   logic [1:0]                   state_ff [bcl_pkg::SLOTS];
   logic [bcl_pkg::AGE_BITS-1:0] age_ff   [bcl_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bcl_pkg::SLOTS; i++) begin
            state_ff[i] <= bcl_pkg::ST_FREE;
         end
      end else if (wr.en && wr.set_state) begin
         state_ff[wr.addr] <= wr.state;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.set_block) begin
         block_ff[wr.addr] <= wr.block;
      end
      if (wr.en && wr.set_age) begin
         age_ff[wr.addr] <= wr.age;
      end
   end

   always_comb begin
      rd_data.block = block_ff[rd_addr];
      rd_data.state = state_ff[rd_addr];
      rd_data.age   = age_ff[rd_addr];
      for (int i = 0; i < bcl_pkg::SLOTS; i++) begin
         occ_mask[i] = (state_ff[i] != bcl_pkg::ST_FREE);
      end
   end

endmodule

`default_nettype wire

>>> rtl/bcl_seq.sv
// ----------------------------------------------------------------------------
// bcl_seq: request sequencer
// Walks the slots one per cycle, unless a stalled result holds it, through a
// single compare/age unit, tracks free slot and victim candidates, then fills
// or reports. Holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcl_seq (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [bcl_pkg::BIF_W-1:0]            blocks_in_file,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [bcl_pkg::KIND_W-1:0]           req_kind,
   input  wire  [bcl_pkg::BLOCK_W-1:0]          req_block_index,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [bcl_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bcl_pkg::SLOT_OUT_W-1:0]       rsp_slot,
   output logic                                 rsp_fill_needed,
   output logic                                 rsp_writeback_valid,
   output logic [bcl_pkg::BLOCK_W-1:0]          rsp_writeback_block,
   output logic                                 rsp_last,
   output logic [bcl_pkg::SLOT_W-1:0]           rd_addr,
   input  wire  bcl_pkg::bcl_rd_type            rd_data,
   output bcl_pkg::bcl_wr_type                  wr,
   input  wire  [bcl_pkg::SLOTS-1:0]            occ_mask
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CHECK  = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   localparam logic [bcl_pkg::SLOT_W-1:0] LAST_IDX = bcl_pkg::SLOT_W'(bcl_pkg::SLOTS - 1);

   logic [1:0]                    st_ff, st_in;
   logic [bcl_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [bcl_pkg::BLOCK_W-1:0]   blk_ff, blk_in;
   logic [bcl_pkg::SLOT_W-1:0]    idx_ff, idx_in;
   logic [bcl_pkg::SLOT_W-1:0]    ptr_ff, ptr_in;
   logic                          free_p_ff, free_p_in;
   logic                          hi_v_ff, hi_v_in;
   logic [bcl_pkg::SLOT_W-1:0]    hi_ff, hi_in;
   logic                          lo_v_ff, lo_v_in;
   logic [bcl_pkg::SLOT_W-1:0]    lo_ff, lo_in;
   logic                          vict_v_ff, vict_v_in;
   logic [bcl_pkg::SLOT_W-1:0]    vict_ff, vict_in;
   logic [bcl_pkg::AGE_BITS-1:0]  vict_age_ff, vict_age_in;
   logic [bcl_pkg::BLOCK_W-1:0]   vict_blk_ff, vict_blk_in;
   logic                          any_ff, any_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bcl_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [bcl_pkg::SLOT_OUT_W-1:0] slot_ff, slot_in;
   logic                          fill_ff, fill_in;
   logic                          wbv_ff, wbv_in;
   logic [bcl_pkg::BLOCK_W-1:0]   wbb_ff, wbb_in;
   logic                          last_ff, last_in;

   logic                          emit, can_emit;
   logic                          occ, match, is_last, above_occ, access_kind;
   logic [bcl_pkg::AGE_BITS-1:0]  age_inc;
   logic [bcl_pkg::SLOT_W-1:0]    fill_slot;
   logic                          fill_ok;

   function automatic logic [bcl_pkg::SLOT_W-1:0] wrap_inc(
      input logic [bcl_pkg::SLOT_W-1:0] p);
      wrap_inc = (p == LAST_IDX) ? '0 : p + bcl_pkg::SLOT_W'(1);
   endfunction

   assign req_stall = (st_ff != S_IDLE);
   assign rd_addr   = idx_ff;
   assign can_emit  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_fill_needed     = fill_ff;
   assign rsp_writeback_valid = wbv_ff;
   assign rsp_writeback_block = wbb_ff;
   assign rsp_last            = last_ff;

   always_comb begin
      occ     = (rd_data.state != bcl_pkg::ST_FREE);
      match   = occ && (rd_data.block == blk_ff);
      is_last = (idx_ff == LAST_IDX);
      age_inc = (rd_data.age == bcl_pkg::AGE_MAX) ? rd_data.age
                                                  : rd_data.age + bcl_pkg::AGE_BITS'(1);
      above_occ = 1'b0;
      for (int j = 0; j < bcl_pkg::SLOTS; j++) begin
         if (occ_mask[j] && (bcl_pkg::SLOT_W'(j) > idx_ff)) begin
            above_occ = 1'b1;
         end
      end
      access_kind = (kind_ff <= bcl_pkg::KIND_UNFIX);

      // fill target: free at pointer, first free above it, first free below it, victim
      fill_ok   = 1'b1;
      fill_slot = ptr_ff;
      if (free_p_ff) begin
         fill_slot = ptr_ff;
      end else if (hi_v_ff) begin
         fill_slot = hi_ff;
      end else if (lo_v_ff) begin
         fill_slot = lo_ff;
      end else if (vict_v_ff) begin
         fill_slot = vict_ff;
      end else begin
         fill_ok = 1'b0;
      end
   end

   always_comb begin
      st_in       = st_ff;
      kind_in     = kind_ff;
      blk_in      = blk_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      free_p_in   = free_p_ff;
      hi_v_in     = hi_v_ff;
      hi_in       = hi_ff;
      lo_v_in     = lo_v_ff;
      lo_in       = lo_ff;
      vict_v_in   = vict_v_ff;
      vict_in     = vict_ff;
      vict_age_in = vict_age_ff;
      vict_blk_in = vict_blk_ff;
      any_in      = any_ff;
      wr          = '0;
      emit        = 1'b0;
      status_in   = bcl_pkg::STATUS_DONE;
      slot_in     = '0;
      fill_in     = 1'b0;
      wbv_in      = 1'b0;
      wbb_in      = '0;
      last_in     = 1'b1;

      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               blk_in  = req_block_index;
               st_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (access_kind && ({1'b0, blk_ff} >= blocks_in_file)) begin
               if (can_emit) begin
                  emit      = 1'b1;
                  status_in = bcl_pkg::STATUS_RANGE;
                  st_in     = S_IDLE;
               end
            end else if (kind_ff > bcl_pkg::KIND_FLUSH) begin
               if (can_emit) begin
                  emit  = 1'b1;
                  st_in = S_IDLE;
               end
            end else begin
               idx_in    = '0;
               free_p_in = 1'b0;
               hi_v_in   = 1'b0;
               lo_v_in   = 1'b0;
               vict_v_in = 1'b0;
               any_in    = 1'b0;
               st_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            case (kind_ff)
               bcl_pkg::KIND_READ, bcl_pkg::KIND_WRITE, bcl_pkg::KIND_FIX: begin
                  if (match) begin
                     if (can_emit) begin
                        wr.en      = 1'b1;
                        wr.addr    = idx_ff;
                        wr.set_age = 1'b1;
                        wr.age     = '0;
                        if (kind_ff == bcl_pkg::KIND_FIX) begin
                           wr.set_state = 1'b1;
                           wr.state     = bcl_pkg::ST_FIXED;
                        end
                        emit      = 1'b1;
                        status_in = bcl_pkg::STATUS_HIT;
                        slot_in   = bcl_pkg::SLOT_OUT_W'(idx_ff);
                        st_in     = S_IDLE;
                     end
                  end else begin
                     if (occ) begin
                        wr.en      = 1'b1;
                        wr.addr    = idx_ff;
                        wr.set_age = 1'b1;
                        wr.age     = age_inc;
                     end else begin
                        if (idx_ff == ptr_ff) begin
                           free_p_in = 1'b1;
                        end else if ((idx_ff > ptr_ff) && !hi_v_ff) begin
                           hi_v_in = 1'b1;
                           hi_in   = idx_ff;
                        end else if ((idx_ff < ptr_ff) && !lo_v_ff) begin
                           lo_v_in = 1'b1;
                           lo_in   = idx_ff;
                        end
                     end
                     // oldest used slot, lowest index on a tie
                     if ((rd_data.state == bcl_pkg::ST_USED) &&
                         (!vict_v_ff || (age_inc > vict_age_ff))) begin
                        vict_v_in   = 1'b1;
                        vict_in     = idx_ff;
                        vict_age_in = age_inc;
                        vict_blk_in = rd_data.block;
                     end
                     if (is_last) begin
                        st_in = S_DECIDE;
                     end else begin
                        idx_in = idx_ff + bcl_pkg::SLOT_W'(1);
                     end
                  end
               end
               bcl_pkg::KIND_UNFIX: begin
                  if (match) begin
                     if (can_emit) begin
                        wr.en        = 1'b1;
                        wr.addr      = idx_ff;
                        wr.set_state = 1'b1;
                        wr.state     = bcl_pkg::ST_USED;
                        emit         = 1'b1;
                        slot_in      = bcl_pkg::SLOT_OUT_W'(idx_ff);
                        st_in        = S_IDLE;
                     end
                  end else if (is_last) begin
                     if (can_emit) begin
                        emit  = 1'b1;
                        st_in = S_IDLE;
                     end
                  end else begin
                     idx_in = idx_ff + bcl_pkg::SLOT_W'(1);
                  end
               end
               bcl_pkg::KIND_UNFIX_ALL: begin
                  if (rd_data.state == bcl_pkg::ST_FIXED) begin
                     wr.en        = 1'b1;
                     wr.addr      = idx_ff;
                     wr.set_state = 1'b1;
                     wr.state     = bcl_pkg::ST_USED;
                  end
                  if (is_last) begin
                     if (can_emit) begin
                        emit  = 1'b1;
                        st_in = S_IDLE;
                     end
                  end else begin
                     idx_in = idx_ff + bcl_pkg::SLOT_W'(1);
                  end
               end
               bcl_pkg::KIND_FLUSH: begin
                  if (occ) begin
                     if (can_emit) begin
                        emit      = 1'b1;
                        status_in = bcl_pkg::STATUS_FLUSH_WB;
                        slot_in   = bcl_pkg::SLOT_OUT_W'(idx_ff);
                        wbv_in    = 1'b1;
                        wbb_in    = rd_data.block;
                        last_in   = !above_occ;
                        any_in    = 1'b1;
                        if (is_last) begin
                           st_in = S_IDLE;
                        end else begin
                           idx_in = idx_ff + bcl_pkg::SLOT_W'(1);
                        end
                     end
                  end else if (is_last) begin
                     if (any_ff) begin
                        st_in = S_IDLE;
                     end else if (can_emit) begin
                        emit  = 1'b1;
                        st_in = S_IDLE;
                     end
                  end else begin
                     idx_in = idx_ff + bcl_pkg::SLOT_W'(1);
                  end
               end
               default: begin
                  st_in = S_IDLE;
               end
            endcase
         end
         S_DECIDE: begin
            if (can_emit) begin
               emit  = 1'b1;
               st_in = S_IDLE;
               if (!fill_ok) begin
                  status_in = (kind_ff == bcl_pkg::KIND_FIX) ? bcl_pkg::STATUS_FIX_FAILED
                                                             : bcl_pkg::STATUS_THROUGH;
               end else begin
                  wr.en        = 1'b1;
                  wr.addr      = fill_slot;
                  wr.set_block = 1'b1;
                  wr.block     = blk_ff;
                  wr.set_state = 1'b1;
                  wr.state     = (kind_ff == bcl_pkg::KIND_FIX) ? bcl_pkg::ST_FIXED
                                                                : bcl_pkg::ST_USED;
                  wr.set_age   = 1'b1;
                  wr.age       = '0;
                  status_in    = bcl_pkg::STATUS_MISS_FILL;
                  slot_in      = bcl_pkg::SLOT_OUT_W'(fill_slot);
                  fill_in      = (kind_ff != bcl_pkg::KIND_WRITE);
                  if (free_p_ff) begin
                     ptr_in = wrap_inc(ptr_ff);
                  end else if (!hi_v_ff && !lo_v_ff) begin
                     // eviction
                     wbv_in = 1'b1;
                     wbb_in = vict_blk_ff;
                     ptr_in = wrap_inc(vict_ff);
                  end
               end
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      blk_ff      <= blk_in;
      idx_ff      <= idx_in;
      free_p_ff   <= free_p_in;
      hi_v_ff     <= hi_v_in;
      hi_ff       <= hi_in;
      lo_v_ff     <= lo_v_in;
      lo_ff       <= lo_in;
      vict_v_ff   <= vict_v_in;
      vict_ff     <= vict_in;
      vict_age_ff <= vict_age_in;
      vict_blk_ff <= vict_blk_in;
      any_ff      <= any_in;
      if (emit) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         fill_ff   <= fill_in;
         wbv_ff    <= wbv_in;
         wbb_ff    <= wbb_in;
         last_ff   <= last_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/block_cache_lru_pinning.sv
// ----------------------------------------------------------------------------
// block_cache_lru_pinning: tag and replacement engine of a block cache
// Fully associative slots with aging LRU, pinning and flush listing.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | kind, block_index
//   rsp     | out       | rsp_valid / rsp_stall   | status, slot, fill_needed,
//           |           |                         | writeback_valid/_block, last
//   csr     | in        | csr_valid / csr_ready   | blocks_in_file
//
// A request runs from its transfer to the next possible transfer through the
// range check state, the scan state that walks the slots one per cycle through
// the single compare/age unit unless a stalled result holds it at a slot with
// a result to give, the fill decision state on a miss, and the idle state in
// which the next request transfers. req_stall is high from the cycle after a
// transfer until the sequencer is idle again; a flush stays busy through the
// free slots after its last result. Reset is synchronous: all slots free,
// pointer and blocks_in_file zero; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module block_cache_lru_pinning (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [bcl_pkg::BIF_W-1:0]         csr_blocks_in_file,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [bcl_pkg::KIND_W-1:0]        req_kind,
   input  wire  [bcl_pkg::BLOCK_W-1:0]       req_block_index,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [bcl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bcl_pkg::SLOT_OUT_W-1:0]    rsp_slot,
   output logic                              rsp_fill_needed,
   output logic                              rsp_writeback_valid,
   output logic [bcl_pkg::BLOCK_W-1:0]       rsp_writeback_block,
   output logic                              rsp_last
);

   logic [bcl_pkg::BIF_W-1:0]  bif_ff, bif_in;
   logic [bcl_pkg::SLOT_W-1:0] rd_addr;
   bcl_pkg::bcl_rd_type        rd_data;
   bcl_pkg::bcl_wr_type        wr;
   logic [bcl_pkg::SLOTS-1:0]  occ_mask;

   assign csr_ready = 1'b1;
   assign bif_in    = (csr_valid && csr_ready) ? csr_blocks_in_file : bif_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bif_ff <= '0;
      end else begin
         bif_ff <= bif_in;
      end
   end

   bcl_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr       (wr),
      .occ_mask (occ_mask)
   );

   bcl_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .blocks_in_file      (bif_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_fill_needed     (rsp_fill_needed),
      .rsp_writeback_valid (rsp_writeback_valid),
      .rsp_writeback_block (rsp_writeback_block),
      .rsp_last            (rsp_last),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data),
      .wr                  (wr),
      .occ_mask            (occ_mask)
   );

   // a transfer always leaves the request engine busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request engine not busy after transfer");

   // only flush produces more than one result
   a_multi_only_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == bcl_pkg::STATUS_FLUSH_WB))
      else $error("non-final result outside flush");

   // writeback only on eviction or flush
   a_wb_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_writeback_valid) |->
         ((rsp_status == bcl_pkg::STATUS_MISS_FILL) ||
          (rsp_status == bcl_pkg::STATUS_FLUSH_WB)))
      else $error("writeback with wrong status");

   // a fill always leaves its slot occupied
   a_fill_occupies: assert property (@(posedge clock) disable iff (reset)
      (wr.en && wr.set_block) |=> occ_mask[$past(wr.addr)])
      else $error("filled slot not occupied");

endmodule

`default_nettype wire

>>> sim/tb_block_cache_lru_pinning.sv
// ----------------------------------------------------------------------------
// tb_block_cache_lru_pinning: self-checking bench for the block cache tag engine
// A queue of requests and blocks_in_file writes feeds a falling-edge driver.
// A behavioral copy of the slot store (blocks, states, ages, fill pointer)
// predicts every result, and the rising-edge monitor checks each result
// transfer in order. The sender works in random bursts and the receiver
// stalls in random modes.
// ----------------------------------------------------------------------------
module tb_block_cache_lru_pinning;
   timeunit 1ns;
   timeprecision 1ps;

   import bcl_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

   // work queue entry types
   localparam logic [1:0] WK_REQ   = 2'd0;
   localparam logic [1:0] WK_CFG   = 2'd1;
   localparam logic [1:0] WK_DRAIN = 2'd2;

   // receiver stall modes
   localparam int RX_OPEN  = 0;
   localparam int RX_LIGHT = 1;
   localparam int RX_HALF  = 2;
   localparam int RX_HEAVY = 3;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_STALL_RUN  = 10;
   localparam int REPORT_MAX     = 10;
   localparam int TAIL_CYCLES    = 24;

   typedef struct packed {
      logic [1:0]          op;
      logic [KIND_W-1:0]   kind;
      logic [BLOCK_W-1:0]  block;
      logic [BIF_W-1:0]    bif;
   } work_item_t;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  fill;
      logic                  wb_valid;
      logic [BLOCK_W-1:0]    wb_block;
      logic                  last;
   } cache_rsp_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [BIF_W-1:0]      csr_blocks_in_file = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [BLOCK_W-1:0]    req_block_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic                  rsp_fill_needed;
   logic                  rsp_writeback_valid;
   logic [BLOCK_W-1:0]    rsp_writeback_block;
   logic                  rsp_last;

   block_cache_lru_pinning dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_blocks_in_file  (csr_blocks_in_file),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_fill_needed     (rsp_fill_needed),
      .rsp_writeback_valid (rsp_writeback_valid),
      .rsp_writeback_block (rsp_writeback_block),
      .rsp_last            (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shadow slot store and result prediction
   // ------------------------------------------------------------------------
   logic [BLOCK_W-1:0]  cache_block [SLOTS];
   logic [1:0]          cache_state [SLOTS];
   logic [AGE_BITS-1:0] cache_age   [SLOTS];
   int                  fill_ptr;
   logic [BIF_W-1:0]    blocks_limit;

   cache_rsp_t cache_rsp_q[$];
   work_item_t work_q[$];

   task automatic expect_rsp(input logic [STATUS_W-1:0] status, input int slot,
                             input logic fill, input logic wbv,
                             input logic [BLOCK_W-1:0] wbb, input logic last);
      cache_rsp_q.push_back({status, SLOT_OUT_W'(slot), fill, wbv, wbb, last});
   endtask

   // scan from slot 0; occupied slots passed before the hit age by one step
   task automatic cache_lookup(input logic [BLOCK_W-1:0] blk, output int hit);
      hit = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && cache_state[i] != ST_FREE) begin
            if (cache_block[i] == blk) begin
               cache_age[i] = '0;
               hit = i;
            end else if (cache_age[i] != AGE_MAX) begin
               cache_age[i] = cache_age[i] + 1'b1;
            end
         end
      end
   endtask

   task automatic cache_take(output int s, output logic wbv, output logic [BLOCK_W-1:0] wbb);
      int p;
      int t;
      int victim;
      p = fill_ptr % SLOTS;
      s = -1;
      victim = -1;
      wbv = 1'b0;
      wbb = '0;
      if (cache_state[p] == ST_FREE) begin
         s = p;
         fill_ptr = (p + 1 >= SLOTS) ? 0 : p + 1;
      end else begin
         // another free slot leaves the pointer where it is
         t = (p + 1) % SLOTS;
         while (t != p && s < 0) begin
            if (cache_state[t] == ST_FREE) s = t;
            else t = (t + 1) % SLOTS;
         end
         if (s < 0) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (cache_state[i] == ST_USED &&
                   (victim < 0 || cache_age[i] > cache_age[victim])) victim = i;
            end
            if (victim >= 0) begin
               wbv = 1'b1;
               wbb = cache_block[victim];
               cache_state[victim] = ST_FREE;
               fill_ptr = (victim + 1 >= SLOTS) ? 0 : victim + 1;
               s = victim;
            end
         end
      end
   endtask

   task automatic predict_cache_rsp(input logic [KIND_W-1:0] kind,
                                    input logic [BLOCK_W-1:0] blk);
      int h;
      int s;
      int n;
      int k;
      logic wbv;
      logic [BLOCK_W-1:0] wbb;
      case (kind)
         KIND_READ, KIND_WRITE, KIND_FIX: begin
            if (blk >= blocks_limit) begin
               expect_rsp(STATUS_RANGE, 0, 1'b0, 1'b0, '0, 1'b1);
            end else begin
               cache_lookup(blk, h);
               if (h >= 0) begin
                  if (kind == KIND_FIX) cache_state[h] = ST_FIXED;
                  expect_rsp(STATUS_HIT, h, 1'b0, 1'b0, '0, 1'b1);
               end else begin
                  cache_take(s, wbv, wbb);
                  if (s < 0) begin
                     expect_rsp((kind == KIND_FIX) ? STATUS_FIX_FAILED : STATUS_THROUGH,
                                0, 1'b0, 1'b0, '0, 1'b1);
                  end else begin
                     cache_block[s] = blk;
                     cache_state[s] = (kind == KIND_FIX) ? ST_FIXED : ST_USED;
                     cache_age[s]   = '0;
                     expect_rsp(STATUS_MISS_FILL, s, kind != KIND_WRITE, wbv, wbb, 1'b1);
                  end
               end
            end
         end
         KIND_UNFIX: begin
            if (blk >= blocks_limit) begin
               expect_rsp(STATUS_RANGE, 0, 1'b0, 1'b0, '0, 1'b1);
            end else begin
               h = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (h < 0 && cache_state[i] != ST_FREE && cache_block[i] == blk) h = i;
               end
               if (h >= 0) cache_state[h] = ST_USED;
               expect_rsp(STATUS_DONE, (h >= 0) ? h : 0, 1'b0, 1'b0, '0, 1'b1);
            end
         end
         KIND_UNFIX_ALL: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (cache_state[i] == ST_FIXED) cache_state[i] = ST_USED;
            end
            expect_rsp(STATUS_DONE, 0, 1'b0, 1'b0, '0, 1'b1);
         end
         KIND_FLUSH: begin
            n = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (cache_state[i] != ST_FREE) n++;
            end
            if (n == 0) begin
               expect_rsp(STATUS_DONE, 0, 1'b0, 1'b0, '0, 1'b1);
            end else begin
               k = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (cache_state[i] != ST_FREE) begin
                     k++;
                     expect_rsp(STATUS_FLUSH_WB, i, 1'b0, 1'b1, cache_block[i], k == n);
                  end
               end
            end
         end
         default: expect_rsp(STATUS_DONE, 0, 1'b0, 1'b0, '0, 1'b1);
      endcase
   endtask

   // ------------------------------------------------------------------------
   // monitor: transfers, result checks, watchdog
   // ------------------------------------------------------------------------
   logic       req_xfer = 1'b0;
   logic       csr_xfer = 1'b0;
   logic       rsp_xfer = 1'b0;
   logic       timed_out = 1'b0;
   int         quiet_cycles = 0;
   int         err_count = 0;
   cache_rsp_t rsp_got;
   cache_rsp_t rsp_want;

   always @(posedge clock) begin
      req_xfer = !reset && req_valid && !req_stall;
      csr_xfer = !reset && csr_valid && csr_ready;
      rsp_xfer = !reset && rsp_valid && !rsp_stall;
      if (csr_xfer) blocks_limit = csr_blocks_in_file;
      if (req_xfer) predict_cache_rsp(req_kind, req_block_index);
      if (rsp_xfer) begin
         rsp_got = {rsp_status, rsp_slot, rsp_fill_needed, rsp_writeback_valid,
                    rsp_writeback_block, rsp_last};
         if (cache_rsp_q.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_MAX)
               $display("%0t: result with nothing pending: st=%0d slot=%0d wbv=%0b wbb=%h",
                        $time, rsp_status, rsp_slot, rsp_writeback_valid,
                        rsp_writeback_block);
         end else begin
            rsp_want = cache_rsp_q.pop_front();
            if (rsp_got.status !== rsp_want.status || rsp_got.slot !== rsp_want.slot ||
                rsp_got.fill !== rsp_want.fill || rsp_got.wb_valid !== rsp_want.wb_valid ||
                rsp_got.wb_block !== rsp_want.wb_block || rsp_got.last !== rsp_want.last) begin
               err_count++;
               if (err_count <= REPORT_MAX)
                  $display({"%0t: result mismatch: exp st=%0d slot=%0d fill=%0b wbv=%0b ",
                            "wbb=%h last=%0b / act st=%0d slot=%0d fill=%0b wbv=%0b ",
                            "wbb=%h last=%0b"}, $time,
                           rsp_want.status, rsp_want.slot, rsp_want.fill,
                           rsp_want.wb_valid, rsp_want.wb_block, rsp_want.last,
                           rsp_got.status, rsp_got.slot, rsp_got.fill,
                           rsp_got.wb_valid, rsp_got.wb_block, rsp_got.last);
            end
         end
      end
      if (!reset) begin
         if (req_xfer || csr_xfer || rsp_xfer) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // driver: requests in bursts, register writes only when nothing is pending
   // ------------------------------------------------------------------------
   int                burst_left = 8;
   int                gap_left = 0;
   logic              nxt_req_v;
   logic              nxt_csr_v;
   logic [KIND_W-1:0] nxt_kind;
   logic [BLOCK_W-1:0] nxt_block;
   logic [BIF_W-1:0]  nxt_bif;
   work_item_t        work_head;

   always @(negedge clock) begin
      if (reset) begin
         req_valid          <= 1'b0;
         req_kind           <= '0;
         req_block_index    <= '0;
         csr_valid          <= 1'b0;
         csr_blocks_in_file <= '0;
      end else begin
         nxt_req_v = req_valid;
         nxt_csr_v = csr_valid;
         nxt_kind  = req_kind;
         nxt_block = req_block_index;
         nxt_bif   = csr_blocks_in_file;
         if (req_valid && req_xfer) begin
            nxt_req_v = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (csr_valid && csr_xfer) nxt_csr_v = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (!nxt_req_v && !nxt_csr_v && work_q.size() > 0) begin
            work_head = work_q[0];
            case (work_head.op)
               WK_REQ: begin
                  nxt_req_v = 1'b1;
                  nxt_kind  = work_head.kind;
                  nxt_block = work_head.block;
                  void'(work_q.pop_front());
               end
               WK_CFG: begin
                  if (cache_rsp_q.size() == 0) begin
                     nxt_csr_v = 1'b1;
                     nxt_bif   = work_head.bif;
                     void'(work_q.pop_front());
                  end
               end
               default: begin
                  if (cache_rsp_q.size() == 0) void'(work_q.pop_front());
               end
            endcase
         end
         req_valid          <= nxt_req_v;
         req_kind           <= nxt_kind;
         req_block_index    <= nxt_block;
         csr_valid          <= nxt_csr_v;
         csr_blocks_in_file <= nxt_bif;
      end
   end

   // receiver: random stall modes, each held for a random span
   int   rx_mode = RX_OPEN;
   int   rx_mode_left = 0;
   int   stall_run = 0;
   logic nxt_stall;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_HEAVY);
            rx_mode_left = $urandom_range(50, 400);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            RX_OPEN:  nxt_stall = 1'b0;
            RX_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
            RX_HALF:  nxt_stall = ($urandom_range(0, 1) == 0);
            default:  nxt_stall = ($urandom_range(0, 7) != 0);
         endcase
         if (stall_run >= MAX_STALL_RUN) nxt_stall = 1'b0;
         stall_run = nxt_stall ? stall_run + 1 : 0;
         rsp_stall <= nxt_stall;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic add_req(input logic [KIND_W-1:0] kind, input logic [BLOCK_W-1:0] blk);
      work_q.push_back({WK_REQ, kind, blk, {BIF_W{1'b0}}});
   endtask

   task automatic add_cfg(input logic [BIF_W-1:0] bif);
      work_q.push_back({WK_CFG, {KIND_W{1'b0}}, {BLOCK_W{1'b0}}, bif});
   endtask

   // a small pool of block numbers keeps hits, pins and evictions frequent
   task automatic add_random_phase(input logic [BIF_W-1:0] bif, input int count);
      logic [BLOCK_W-1:0] pool [12];
      logic [KIND_W-1:0]  kind;
      logic [BLOCK_W-1:0] blk;
      int                 pick;
      add_cfg(bif);
      for (int i = 0; i < 12; i++)
         pool[i] = BLOCK_W'((bif > 12) ? $urandom_range(0, bif - 1)
                                       : $urandom_range(0, 15));
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) work_q.push_back({WK_DRAIN, {KIND_W{1'b0}},
                                              {BLOCK_W{1'b0}}, {BIF_W{1'b0}}});
         pick = $urandom_range(0, 99);
         if (pick < 34)      kind = KIND_READ;
         else if (pick < 58) kind = KIND_WRITE;
         else if (pick < 70) kind = KIND_FIX;
         else if (pick < 80) kind = KIND_UNFIX;
         else if (pick < 85) kind = KIND_UNFIX_ALL;
         else if (pick < 94) kind = KIND_FLUSH;
         else if (pick < 97) kind = KIND_SPARE6;
         else                kind = KIND_SPARE7;
         blk = ($urandom_range(0, 9) == 0) ? BLOCK_W'($urandom_range(0, 65535))
                                          : pool[$urandom_range(0, 11)];
         add_req(kind, blk);
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         cache_block[i] = '0;
         cache_state[i] = ST_FREE;
         cache_age[i]   = '0;
      end
      fill_ptr = 0;
      blocks_limit = '0;

      // empty store, no valid blocks
      add_req(KIND_READ, 16'h0000);
      add_req(KIND_UNFIX, 16'h0000);
      add_req(KIND_FLUSH, 16'h0000);
      add_req(KIND_UNFIX_ALL, 16'h0000);

      // a pinned slot 0 ages on every scan past it; once released it is the
      // oldest and goes first when the store is full
      add_cfg(17'd65536);
      add_req(KIND_FIX, 16'hA5A5);
      add_req(KIND_READ, 16'h5A5A);
      add_req(KIND_UNFIX, 16'hA5A5);
      for (int i = 1; i <= 6; i++) add_req(KIND_READ, 16'h0100 + i[15:0]);
      add_req(KIND_READ, 16'h0107);

      // full store: hits, evictions with writeback, pins
      add_req(KIND_READ, 16'h5A5A);
      add_req(KIND_WRITE, 16'h0000);
      add_req(KIND_READ, 16'hFFFF);
      add_req(KIND_FIX, 16'hFFFF);
      add_req(KIND_WRITE, 16'hFFFF);
      add_req(KIND_UNFIX, 16'hFFFF);
      add_req(KIND_UNFIX, 16'h1357);
      add_req(KIND_FLUSH, 16'h0000);
      add_req(KIND_UNFIX_ALL, 16'h0000);
      // eight distinct pins leave every slot fixed
      for (int i = 0; i < SLOTS; i++) add_req(KIND_FIX, i[15:0]);
      add_req(KIND_READ, 16'd100);
      add_req(KIND_WRITE, 16'd101);
      add_req(KIND_FIX, 16'd102);
      add_req(KIND_FLUSH, 16'h0000);
      add_req(KIND_UNFIX, 16'd3);
      add_req(KIND_UNFIX_ALL, 16'h0000);
      add_req(KIND_SPARE6, 16'hFFFF);
      add_req(KIND_SPARE7, 16'h0000);

      // range boundary
      add_cfg(17'd8);
      add_req(KIND_READ, 16'd8);
      add_req(KIND_FIX, 16'd7);
      add_req(KIND_WRITE, 16'hFFFF);
      add_req(KIND_UNFIX, 16'd9);

      add_random_phase(17'd12, 110);
      add_random_phase(17'd65536, 110);
      add_random_phase(BIF_W'($urandom_range(1, 65535)), 100);
      add_random_phase(17'd1, 50);
      add_random_phase(17'd0, 10);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!timed_out && !(work_q.size() == 0 && !req_valid && !csr_valid &&
                             cache_rsp_q.size() == 0))
         @(posedge clock);
      if (!timed_out) repeat (TAIL_CYCLES) @(posedge clock);

      if (timed_out) begin
         $display("tb_block_cache_lru_pinning: errors");
      end else begin
         if (err_count == 0 && cache_rsp_q.size() == 0) begin
            $display("tb_block_cache_lru_pinning: clean");
         end else begin
            $display("tb_block_cache_lru_pinning: errors");
         end
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/bcl_pkg.sv
rtl/bcl_store.sv
rtl/bcl_seq.sv
rtl/block_cache_lru_pinning.sv
sim/tb_block_cache_lru_pinning.sv
